FILE: sv/punf_pkg.sv
package punf_pkg;

   // Line buffer geometry
   localparam int MAX_ROW_BYTES = 8192;
   localparam int ROW_ADDR_W    = $clog2(MAX_ROW_BYTES);
   localparam int ROW_CNT_W     = ROW_ADDR_W + 1;

   // Pixel format limits
   localparam int CH_MAX        = 4;
   localparam int CH_IDX_W      = $clog2(CH_MAX);

   // Register widths
   localparam int WIDTH_W       = 12;
   localparam int HEIGHT_W      = 25;
   localparam int CHANS_W       = 3;

   // Per-channel width caps so that one row fits the line buffer
   localparam logic [ROW_CNT_W-1:0] CAP_CH1 = ROW_CNT_W'(MAX_ROW_BYTES / 1);
   localparam logic [ROW_CNT_W-1:0] CAP_CH2 = ROW_CNT_W'(MAX_ROW_BYTES / 2);
   localparam logic [ROW_CNT_W-1:0] CAP_CH3 = ROW_CNT_W'(MAX_ROW_BYTES / 3);
   localparam logic [ROW_CNT_W-1:0] CAP_CH4 = ROW_CNT_W'(MAX_ROW_BYTES / 4);

   // Highest legal filter code and the alpha fill value
   localparam logic [7:0] FILTER_MAX = 8'd4;
   localparam logic [7:0] ALPHA_FILL = 8'd255;

   // Result queue
   localparam int Q_DEPTH = 8;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   // Register map (word index = paddr[3:2])
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CHANNELS     = 2'd2;
   localparam logic [1:0] CSR_ADD_ALPHA    = 2'd3;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   // One result word
   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       is_fill;
      logic       run_last;
      logic       image_last;
      logic       bad_filter;
   } rsp_word_type;

   // Work carried from the accept stage into the reconstruct stage
   typedef struct packed {
      logic                  is_data;   // 0: filter byte, clears the neighbors
      logic [CH_IDX_W-1:0]   ci;
      logic [ROW_ADDR_W-1:0] col;
      filter_type            flt;
      logic                  has_up;
      logic                  err;
      logic                  fill;
      logic                  img_last;
      logic [7:0]            raw;
   } stage_type;

endpackage

FILE: sv/punf_req_if.sv
interface punf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       image_start;

   modport source (output valid, output stream_byte, output image_start, input ready);
   modport sink   (input valid, input stream_byte, input image_start, output ready);
endinterface

FILE: sv/punf_rsp_if.sv
interface punf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       is_fill;
   logic       run_last;
   logic       image_last;
   logic       bad_filter;

   modport source (output valid, output pixel_byte, output is_fill, output run_last,
                   output image_last, output bad_filter, input ready);
   modport sink   (input valid, input pixel_byte, input is_fill, input run_last,
                   input image_last, input bad_filter, output ready);
endinterface

FILE: sv/png_row_unfilter_8bit.sv
// PNG scanline reconstruction for 8-bit samples. Feed the inflated stream one
// word per cycle; the first word of each row is the filter type and gives no
// result, each channel word gives one reconstructed byte, plus a 255 alpha word
// after each pixel when add_alpha is set with 1 or 3 channels. The block takes
// one input word per cycle while ready is high: the accept stage reads the
// previous row from an 8192x8 line buffer with one read port and one write
// port, the next stage applies the filter, writes the byte back and queues the
// results, so a result word passes the stage register and the result queue
// before it is offered. Output runs one word per cycle while the consumer is
// ready, so with alpha fill the eight-word result queue backs up and holds off
// input, as it also does while the consumer stalls. The line buffer is not
// cleared after reset; the first row of an image ignores what it reads, and
// every later row reads only columns the row before it wrote. A filter code
// above 4 flags bad_filter on every result until the next image_start.
module png_row_unfilter_8bit (
   input  logic                            clock,
   input  logic                            reset,
   punf_req_if.sink                        req_chan,
   punf_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [punf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [punf_pkg::WIDTH_W-1:0]  width_ff;
   logic [punf_pkg::HEIGHT_W-1:0] height_ff;
   logic [punf_pkg::CHANS_W-1:0]  chans_ff;
   logic                          add_alpha_ff;
   logic                          csr_wr;
   logic [1:0]                    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= punf_pkg::WIDTH_W'(1);
         height_ff    <= punf_pkg::HEIGHT_W'(1);
         chans_ff     <= punf_pkg::CHANS_W'(4);
         add_alpha_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            punf_pkg::CSR_IMAGE_WIDTH:  width_ff     <= csr_pwdata[punf_pkg::WIDTH_W-1:0];
            punf_pkg::CSR_IMAGE_HEIGHT: height_ff    <= csr_pwdata[punf_pkg::HEIGHT_W-1:0];
            punf_pkg::CSR_CHANNELS:     chans_ff     <= csr_pwdata[punf_pkg::CHANS_W-1:0];
            punf_pkg::CSR_ADD_ALPHA:    add_alpha_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         punf_pkg::CSR_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         punf_pkg::CSR_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         punf_pkg::CSR_CHANNELS:     csr_prdata = 32'(chans_ff);
         punf_pkg::CSR_ADD_ALPHA:    csr_prdata = 32'(add_alpha_ff);
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------
   // Effective geometry (out-of-range settings clamped)
   // ---------------------------------------------------------------
   logic [punf_pkg::CHANS_W-1:0]   ch_eff;
   logic [punf_pkg::ROW_CNT_W-1:0] w_raw;
   logic [punf_pkg::ROW_CNT_W-1:0] w_cap;
   logic [punf_pkg::ROW_CNT_W-1:0] w_eff;
   logic [punf_pkg::ROW_CNT_W-1:0] row_bytes;
   logic [punf_pkg::HEIGHT_W-1:0]  h_eff;
   logic                           alpha_ok;

   always_comb begin
      if (chans_ff == '0) begin
         ch_eff = punf_pkg::CHANS_W'(1);
      end else if (chans_ff > punf_pkg::CHANS_W'(punf_pkg::CH_MAX)) begin
         ch_eff = punf_pkg::CHANS_W'(punf_pkg::CH_MAX);
      end else begin
         ch_eff = chans_ff;
      end

      w_raw = (width_ff == '0) ? punf_pkg::ROW_CNT_W'(1) : punf_pkg::ROW_CNT_W'(width_ff);

      case (ch_eff)
         3'd1:    w_cap = punf_pkg::CAP_CH1;
         3'd2:    w_cap = punf_pkg::CAP_CH2;
         3'd3:    w_cap = punf_pkg::CAP_CH3;
         default: w_cap = punf_pkg::CAP_CH4;
      endcase
      w_eff = (w_raw > w_cap) ? w_cap : w_raw;

      // width times 1..4 as shifts and one add
      case (ch_eff)
         3'd1:    row_bytes = w_eff;
         3'd2:    row_bytes = w_eff << 1;
         3'd3:    row_bytes = w_eff + (w_eff << 1);
         default: row_bytes = w_eff << 2;
      endcase

      h_eff    = (height_ff == '0) ? punf_pkg::HEIGHT_W'(1) : height_ff;
      alpha_ok = add_alpha_ff && ((ch_eff == 3'd1) || (ch_eff == 3'd3));
   end

   // ---------------------------------------------------------------
   // Accept stage: position tracking and line buffer read
   // ---------------------------------------------------------------
   logic                            awaiting_ff, awaiting_in;
   punf_pkg::filter_type            filter_ff, filter_in;
   logic                            err_ff, err_in;
   logic [punf_pkg::ROW_ADDR_W-1:0] col_ff, col_in;
   logic [punf_pkg::CH_IDX_W-1:0]   chi_ff, chi_in;
   logic [punf_pkg::HEIGHT_W-1:0]   row_ff, row_in;
   logic                            s1_valid_ff, s1_valid_in;
   punf_pkg::stage_type             s1_ff, s1_in;

   logic                            req_accept;
   logic                            eff_await;
   logic                            eff_err;
   logic [punf_pkg::ROW_ADDR_W-1:0] eff_col;
   logic [punf_pkg::CH_IDX_W-1:0]   eff_chi;
   logic [punf_pkg::HEIGHT_W-1:0]   eff_row;
   logic                            in_image;
   logic                            row_end;
   logic                            pix_end;
   logic                            rd_en;
   logic                            bad_code;

   assign req_accept = req_chan.valid && req_chan.ready;

   // image start resets position before the word is looked at
   assign eff_await = req_chan.image_start || awaiting_ff;
   assign eff_err   = req_chan.image_start ? 1'b0 : err_ff;
   assign eff_col   = req_chan.image_start ? '0 : col_ff;
   assign eff_chi   = req_chan.image_start ? '0 : chi_ff;
   assign eff_row   = req_chan.image_start ? '0 : row_ff;
   assign in_image  = eff_row < h_eff;
   assign bad_code  = req_chan.stream_byte > punf_pkg::FILTER_MAX;

   assign row_end = ({1'b0, eff_col} + punf_pkg::ROW_CNT_W'(1)) >= row_bytes;
   assign pix_end = row_end ||
                    (({1'b0, eff_chi} + punf_pkg::CHANS_W'(1)) >= ch_eff);
   assign rd_en   = req_accept && in_image && !eff_await;

   always_comb begin
      awaiting_in = awaiting_ff;
      filter_in   = filter_ff;
      err_in      = err_ff;
      col_in      = col_ff;
      chi_in      = chi_ff;
      row_in      = row_ff;
      s1_valid_in = 1'b0;
      s1_in       = s1_ff;
      if (req_accept) begin
         awaiting_in = eff_await;
         err_in      = eff_err;
         col_in      = eff_col;
         chi_in      = eff_chi;
         row_in      = eff_row;
         if (in_image) begin
            s1_valid_in    = 1'b1;
            s1_in.ci       = eff_chi;
            s1_in.col      = eff_col;
            s1_in.flt      = filter_ff;
            s1_in.has_up   = eff_row != '0;
            s1_in.err      = eff_err;
            s1_in.fill     = alpha_ok && pix_end;
            s1_in.img_last = row_end &&
                             (({1'b0, eff_row} + (punf_pkg::HEIGHT_W + 1)'(1)) >=
                              {1'b0, h_eff});
            s1_in.raw      = req_chan.stream_byte;
            if (eff_await) begin
               // filter type word
               s1_in.is_data = 1'b0;
               awaiting_in   = 1'b0;
               col_in        = '0;
               chi_in        = '0;
               if (bad_code) begin
                  err_in    = 1'b1;
                  filter_in = punf_pkg::FILT_NONE;
               end else begin
                  filter_in = punf_pkg::filter_type'(req_chan.stream_byte[2:0]);
               end
            end else begin
               // channel word
               s1_in.is_data = 1'b1;
               chi_in        = pix_end ? '0 : eff_chi + punf_pkg::CH_IDX_W'(1);
               if (row_end) begin
                  awaiting_in = 1'b1;
                  row_in      = eff_row + punf_pkg::HEIGHT_W'(1);
                  col_in      = '0;
               end else begin
                  col_in      = eff_col + punf_pkg::ROW_ADDR_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b1;
         filter_ff   <= punf_pkg::FILT_NONE;
         err_ff      <= 1'b0;
         col_ff      <= '0;
         chi_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         awaiting_ff <= awaiting_in;
         filter_ff   <= filter_in;
         err_ff      <= err_in;
         col_ff      <= col_in;
         chi_ff      <= chi_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // ---------------------------------------------------------------
   // Line buffer: read at accept, written back from the next stage.
   // Consecutive data words never share a column, so no bypass.
   // ---------------------------------------------------------------
   logic [7:0] row_store [punf_pkg::MAX_ROW_BYTES];
   logic [7:0] rd_data_ff;
   logic       wr_en;
   logic [7:0] recon;

   assign wr_en = s1_valid_ff && s1_ff.is_data;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_store[eff_col];
      end
      if (wr_en) begin
         row_store[s1_ff.col] <= recon;
      end
   end

   // ---------------------------------------------------------------
   // Reconstruct stage
   // ---------------------------------------------------------------
   logic [7:0] left_ff    [punf_pkg::CH_MAX];
   logic [7:0] upleft_ff  [punf_pkg::CH_MAX];
   logic [7:0] nb_a, nb_b, nb_c;
   logic [8:0] avg_sum;
   logic [9:0] d_bc, d_ac, d_abc;
   logic [9:0] pa, pb, pc;
   logic [7:0] paeth;
   logic [7:0] pred;

   assign nb_a = left_ff[s1_ff.ci];
   assign nb_c = upleft_ff[s1_ff.ci];
   assign nb_b = s1_ff.has_up ? rd_data_ff : 8'd0;

   always_comb begin
      avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

      // Paeth distances: |b-c|, |a-c|, |a+b-2c|
      d_bc  = {2'b00, nb_b} - {2'b00, nb_c};
      d_ac  = {2'b00, nb_a} - {2'b00, nb_c};
      d_abc = {2'b00, nb_a} + {2'b00, nb_b} - {1'b0, nb_c, 1'b0};
      pa    = d_bc[9]  ? (10'd0 - d_bc)  : d_bc;
      pb    = d_ac[9]  ? (10'd0 - d_ac)  : d_ac;
      pc    = d_abc[9] ? (10'd0 - d_abc) : d_abc;
      if ((pa <= pb) && (pa <= pc)) begin
         paeth = nb_a;
      end else if (pb <= pc) begin
         paeth = nb_b;
      end else begin
         paeth = nb_c;
      end

      case (s1_ff.flt)
         punf_pkg::FILT_SUB:   pred = nb_a;
         punf_pkg::FILT_UP:    pred = nb_b;
         punf_pkg::FILT_AVG:   pred = avg_sum[8:1];
         punf_pkg::FILT_PAETH: pred = paeth;
         default:              pred = 8'd0;
      endcase
      recon = s1_ff.raw + pred;
   end

   // neighbor registers; a filter word clears them for the new row
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < punf_pkg::CH_MAX; i++) begin
            left_ff[i]   <= 8'd0;
            upleft_ff[i] <= 8'd0;
         end
      end else if (s1_valid_ff && !s1_ff.is_data) begin
         for (int i = 0; i < punf_pkg::CH_MAX; i++) begin
            left_ff[i]   <= 8'd0;
            upleft_ff[i] <= 8'd0;
         end
      end else if (wr_en) begin
         left_ff[s1_ff.ci]   <= recon;
         upleft_ff[s1_ff.ci] <= nb_b;
      end
   end

   // result words for this input
   punf_pkg::rsp_word_type word0, word1;
   logic [1:0]             push_n;

   always_comb begin
      word0.pixel_byte = s1_ff.err ? 8'd0 : recon;
      word0.is_fill    = 1'b0;
      word0.run_last   = !s1_ff.fill;
      word0.image_last = s1_ff.img_last && !s1_ff.fill;
      word0.bad_filter = s1_ff.err;

      word1.pixel_byte = punf_pkg::ALPHA_FILL;
      word1.is_fill    = 1'b1;
      word1.run_last   = 1'b1;
      word1.image_last = s1_ff.img_last;
      word1.bad_filter = s1_ff.err;

      if (!wr_en) begin
         push_n = 2'd0;
      end else if (s1_ff.fill) begin
         push_n = 2'd2;
      end else begin
         push_n = 2'd1;
      end
   end

   // ---------------------------------------------------------------
   // Result queue; input is held off while a word in flight could
   // find it full
   // ---------------------------------------------------------------
   punf_pkg::rsp_word_type          q_mem [punf_pkg::Q_DEPTH];
   logic [punf_pkg::Q_PTR_W-1:0]    q_wr_ff, q_wr_in;
   logic [punf_pkg::Q_PTR_W-1:0]    q_rd_ff, q_rd_in;
   logic [punf_pkg::Q_CNT_W-1:0]    q_count_ff, q_count_in;
   logic [punf_pkg::Q_PTR_W-1:0]    q_wr_next;
   logic [punf_pkg::Q_CNT_W:0]      q_pending;
   logic                            rsp_pop;
   punf_pkg::rsp_word_type          q_head;

   assign q_wr_next = q_wr_ff + punf_pkg::Q_PTR_W'(1);
   assign rsp_pop   = rsp_chan.valid && rsp_chan.ready;
   assign q_pending = {1'b0, q_count_ff} +
                      (s1_valid_ff ? (punf_pkg::Q_CNT_W + 1)'(2) : '0);

   assign req_chan.ready = q_pending <= (punf_pkg::Q_CNT_W + 1)'(punf_pkg::Q_DEPTH - 2);

   always_comb begin
      q_wr_in    = q_wr_ff + punf_pkg::Q_PTR_W'(push_n);
      q_rd_in    = q_rd_ff + punf_pkg::Q_PTR_W'(rsp_pop);
      q_count_in = q_count_ff + punf_pkg::Q_CNT_W'(push_n) - punf_pkg::Q_CNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff    <= '0;
         q_rd_ff    <= '0;
         q_count_ff <= '0;
      end else begin
         q_wr_ff    <= q_wr_in;
         q_rd_ff    <= q_rd_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_mem[q_wr_ff] <= word0;
      end
      if (push_n == 2'd2) begin
         q_mem[q_wr_next] <= word1;
      end
   end

   assign q_head              = q_mem[q_rd_ff];
   assign rsp_chan.valid      = q_count_ff != '0;
   assign rsp_chan.pixel_byte = q_head.pixel_byte;
   assign rsp_chan.is_fill    = q_head.is_fill;
   assign rsp_chan.run_last   = q_head.run_last;
   assign rsp_chan.image_last = q_head.image_last;
   assign rsp_chan.bad_filter = q_head.bad_filter;

`ifndef NO_ASSERTIONS
   // queue never overflows
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= punf_pkg::Q_CNT_W'(punf_pkg::Q_DEPTH))
      else $error("result queue overflow");

   // read and write-back never hit the same column in one cycle
   a_no_col_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (eff_col != s1_ff.col))
      else $error("line buffer read/write clash");

   // every accepted channel word yields results in the next cycle
   a_data_pushes: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (push_n != 2'd0))
      else $error("channel word produced no result");

   // the alpha word is already queued behind its channel word
   a_fill_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !q_head.run_last) |=> rsp_chan.valid)
      else $error("alpha fill word missing");
`endif

endmodule

FILE: tb/png_row_unfilter_8bit_tb.sv
module png_row_unfilter_8bit_tb;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 8;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int RANDOM_BYTES = 620;
   localparam int WIDE_BYTES   = 200;
   localparam int CAP_BYTES    = 150;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } stream_word_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [punf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   punf_req_if req_if ();
   punf_rsp_if rsp_if ();

   png_row_unfilter_8bit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copies of the format registers
   logic [punf_pkg::WIDTH_W-1:0]  cfg_width     = 1;
   logic [punf_pkg::HEIGHT_W-1:0] cfg_height    = 1;
   logic [punf_pkg::CHANS_W-1:0]  cfg_channels  = 4;
   logic                          cfg_add_alpha = 1'b0;

   // Predicted unfilter state
   logic [7:0]           prev_row [punf_pkg::MAX_ROW_BYTES];
   logic [7:0]           left_px [punf_pkg::CH_MAX]   = '{default: 8'd0};
   logic [7:0]           upleft_px [punf_pkg::CH_MAX] = '{default: 8'd0};
   punf_pkg::filter_type row_filter                   = punf_pkg::FILT_NONE;
   bit                   want_filter                  = 1'b1;
   int unsigned          col_pos                      = 0;
   int unsigned          chan_pos                     = 0;
   int unsigned          row_pos                      = 0;
   bit                   err_flag                     = 1'b0;

   stream_word_type        pending_bytes[$];
   punf_pkg::rsp_word_type expected_pixels[$];
   stream_word_type        drive_word;
   punf_pkg::rsp_word_type seen_word;
   punf_pkg::rsp_word_type due_word;

   int          mismatches     = 0;
   int          cycle_count    = 0;
   int unsigned row_words      = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   bit          long_hold_go   = 1'b0;
   bit          long_hold_used;
   int          hold_left;

   function automatic int unsigned eff_channels();
      if (cfg_channels == 0) return 1;
      if (cfg_channels > punf_pkg::CH_MAX) return punf_pkg::CH_MAX;
      return cfg_channels;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   // Row length in bytes, width capped so the row fits the line buffer
   function automatic int unsigned row_len();
      int unsigned chans;
      int unsigned wpix;
      chans = eff_channels();
      wpix  = (cfg_width == 0) ? 1 : cfg_width;
      if (wpix > punf_pkg::MAX_ROW_BYTES / chans) wpix = punf_pkg::MAX_ROW_BYTES / chans;
      return wpix * chans;
   endfunction

   function automatic logic [7:0] paeth_choice(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
      int p;
      int pa;
      int pb;
      int pc;
      p  = int'(a) + int'(b) - int'(c);
      pa = p - int'(a);
      pb = p - int'(b);
      pc = p - int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   function automatic void clear_position();
      col_pos   = 0;
      chan_pos  = 0;
      left_px   = '{default: 8'd0};
      upleft_px = '{default: 8'd0};
   endfunction

   // Rebuild one accepted stream word and queue the pixel words it causes
   task automatic unfilter_predict(input logic [7:0] din, input logic start);
      int unsigned            chans;
      int unsigned            nbytes;
      int unsigned            ci;
      int unsigned            pred;
      logic [7:0]             a;
      logic [7:0]             b;
      logic [7:0]             c;
      logic [7:0]             x;
      bit                     row_end;
      bit                     pix_end;
      bit                     fill;
      bit                     img_last;
      punf_pkg::rsp_word_type word;
      if (start) begin
         clear_position();
         want_filter = 1'b1;
         row_pos     = 0;
         err_flag    = 1'b0;
      end
      chans  = eff_channels();
      nbytes = row_len();
      // past the last row: nothing until the next image start
      if (row_pos >= eff_height()) return;
      if (want_filter) begin
         if (din > punf_pkg::FILTER_MAX) begin
            err_flag   = 1'b1;
            row_filter = punf_pkg::FILT_NONE;
         end else begin
            row_filter = punf_pkg::filter_type'(din[2:0]);
         end
         want_filter = 1'b0;
         clear_position();
         return;
      end
      ci = chan_pos & 3;
      a  = left_px[ci];
      c  = upleft_px[ci];
      b  = (row_pos != 0 && col_pos < punf_pkg::MAX_ROW_BYTES) ? prev_row[col_pos] : 8'd0;
      case (row_filter)
         punf_pkg::FILT_SUB:   pred = a;
         punf_pkg::FILT_UP:    pred = b;
         punf_pkg::FILT_AVG:   pred = (int'(a) + int'(b)) >> 1;
         punf_pkg::FILT_PAETH: pred = paeth_choice(a, b, c);
         default:              pred = 0;
      endcase
      x = din + pred[7:0];
      if (col_pos < punf_pkg::MAX_ROW_BYTES) prev_row[col_pos] = x;
      left_px[ci]   = x;
      upleft_px[ci] = b;

      row_end  = (col_pos + 1) >= nbytes;
      pix_end  = ((chan_pos + 1) >= chans) || row_end;
      fill     = cfg_add_alpha && (chans == 1 || chans == 3) && pix_end;
      img_last = row_end && ((row_pos + 1) >= eff_height());

      word.pixel_byte = err_flag ? 8'd0 : x;
      word.is_fill    = 1'b0;
      word.run_last   = !fill;
      word.image_last = img_last && !fill;
      word.bad_filter = err_flag;
      expected_pixels.push_back(word);
      if (fill) begin
         word.pixel_byte = punf_pkg::ALPHA_FILL;
         word.is_fill    = 1'b1;
         word.run_last   = 1'b1;
         word.image_last = img_last;
         word.bad_filter = err_flag;
         expected_pixels.push_back(word);
      end

      chan_pos = pix_end ? 0 : ((ci + 1) & 3);
      if (row_end) begin
         want_filter = 1'b1;
         row_pos     = (row_pos + 1) & 32'h1FF_FFFF;
         col_pos     = 0;
      end else begin
         col_pos++;
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit reached", $time);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Input driver: next word once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_word = pending_bytes.pop_front();
            req_if.valid       <= 1'b1;
            req_if.stream_byte <= drive_word.data;
            req_if.image_start <= drive_word.start;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Predict on every accepted input word
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         unfilter_predict(req_if.stream_byte, req_if.image_start);
   end

   // Result ready: random stalls, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready   <= 1'b0;
         hold_left      <= 0;
         long_hold_used <= 1'b0;
      end else if (long_hold_go && !long_hold_used) begin
         long_hold_used <= 1'b1;
         hold_left      <= LONG_HOLD;
         rsp_if.ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen_word = {rsp_if.pixel_byte, rsp_if.is_fill, rsp_if.run_last,
                      rsp_if.image_last, rsp_if.bad_filter};
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected word: byte=%02h fill=%b last=%b img_last=%b bad=%b",
                     $time, seen_word.pixel_byte, seen_word.is_fill, seen_word.run_last,
                     seen_word.image_last, seen_word.bad_filter);
            mismatches++;
         end else begin
            due_word = expected_pixels.pop_front();
            if (seen_word !== due_word) begin
               $display({"%0t: expected byte=%02h fill=%b last=%b img_last=%b bad=%b,",
                         " got byte=%02h fill=%b last=%b img_last=%b bad=%b"},
                        $time, due_word.pixel_byte, due_word.is_fill, due_word.run_last,
                        due_word.image_last, due_word.bad_filter,
                        seen_word.pixel_byte, seen_word.is_fill, seen_word.run_last,
                        seen_word.image_last, seen_word.bad_filter);
               mismatches++;
            end
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         punf_pkg::CSR_IMAGE_WIDTH:  cfg_width     = value[punf_pkg::WIDTH_W-1:0];
         punf_pkg::CSR_IMAGE_HEIGHT: cfg_height    = value[punf_pkg::HEIGHT_W-1:0];
         punf_pkg::CSR_CHANNELS:     cfg_channels  = value[punf_pkg::CHANS_W-1:0];
         punf_pkg::CSR_ADD_ALPHA:    cfg_add_alpha = value[0];
         default: ;
      endcase
   endtask

   task automatic set_format(input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] ch, input logic [31:0] alpha);
      write_csr(punf_pkg::CSR_IMAGE_WIDTH, w);
      write_csr(punf_pkg::CSR_IMAGE_HEIGHT, h);
      write_csr(punf_pkg::CSR_CHANNELS, ch);
      write_csr(punf_pkg::CSR_ADD_ALPHA, alpha);
   endtask

   // 0: none, 1: sender idles, 2: receiver stalls, 3: both
   function automatic void set_idle(input int mode);
      case (mode)
         1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
         3:       begin send_idle_pct = 27; recv_stall_pct = 27; end
         default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endfunction

   function automatic void push_word(input logic [7:0] data, input logic start);
      stream_word_type word;
      word.data  = data;
      word.start = start;
      pending_bytes.push_back(word);
   endfunction

   function automatic logic [7:0] random_filter();
      if ($urandom_range(11) == 0) return 8'($urandom_range(255, 5));
      return 8'($urandom_range(4));
   endfunction

   // Filter word plus one row of random channel words; a few stray image starts
   task automatic push_row(input logic [7:0] flt, input bit first, input int unsigned broken_pct);
      int unsigned n;
      n = row_len();
      push_word(flt, first);
      repeat (n) push_word(8'($urandom_range(255)), $urandom_range(99) < broken_pct);
      row_words += n + 1;
   endtask

   // Image start with a filter word and the leading part of a long first row
   task automatic push_row_head(input int unsigned n);
      push_word(random_filter(), 1'b1);
      repeat (n) push_word(8'($urandom_range(255)), 1'b0);
   endtask

   // Mostly whole images; some cut short, some with trailing words
   task automatic build_random_image();
      int unsigned hgt;
      int unsigned rows;
      int unsigned extra;
      hgt = eff_height();
      if (hgt > 6) rows = $urandom_range(1, 6);
      else if ($urandom_range(4) == 0) rows = $urandom_range(1, hgt);
      else rows = hgt;
      extra = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
      for (int r = 0; r < rows; r++) push_row(random_filter(), r == 0, 2);
      repeat (extra) push_word(8'($urandom_range(255)), $urandom_range(15) == 0);
   endtask

   // Let the queued words go, wait for every prediction, then let the pipe settle
   task automatic run_queued();
      int waited;
      while (pending_bytes.size() != 0 || req_if.valid) @(posedge clock);
      waited = 0;
      while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_pixels.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, expected_pixels.size());
         mismatches++;
         expected_pixels.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned ch;
      int unsigned imgs;
      int unsigned base;
      int          mode;

      req_if.valid       = 1'b0;
      req_if.stream_byte = 8'd0;
      req_if.image_start = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      reset              = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Paeth on the first row, Sub, Paeth with a row above, a word past the image
      set_format(2, 3, 1, 1);
      set_idle(0);
      @(negedge clock);
      push_word(8'd4, 1'b1);
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'd1, 1'b0);
      push_word(8'h01, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'd4, 1'b0);
      push_word(8'h80, 1'b0);
      push_word(8'h7F, 1'b0);
      push_word(8'h12, 1'b0);
      run_queued();

      // Average on the first row, Up, then a bad filter that sticks over the next row
      set_format(1, 4, 2, 0);
      set_idle(3);
      @(negedge clock);
      push_word(8'd3, 1'b1);
      push_word(8'hFF, 1'b0);
      push_word(8'h01, 1'b0);
      push_word(8'd2, 1'b0);
      push_word(8'h80, 1'b0);
      push_word(8'h02, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'h55, 1'b0);
      push_word(8'hAA, 1'b0);
      push_word(8'd1, 1'b0);
      push_word(8'h10, 1'b0);
      push_word(8'hF0, 1'b0);
      run_queued();

      // Receiver holds off long enough for the input to back up
      set_format(16, 4, 3, 1);
      set_idle(0);
      @(negedge clock);
      long_hold_go = 1'b1;
      for (int r = 0; r < 4; r++) push_row(random_filter(), r == 0, 0);
      run_queued();

      // Format changed between rows of one image, after the sender drains
      set_format(4, 4, 3, 1);
      set_idle(3);
      @(negedge clock);
      push_row(random_filter(), 1'b1, 0);
      push_row(random_filter(), 1'b0, 0);
      run_queued();
      write_csr(punf_pkg::CSR_IMAGE_WIDTH, 3);
      write_csr(punf_pkg::CSR_CHANNELS, 2);
      @(negedge clock);
      push_row(random_filter(), 1'b0, 0);
      push_row(random_filter(), 1'b0, 0);
      run_queued();

      // Random formats and images
      mode = 0;
      base = row_words;
      while (row_words - base < RANDOM_BYTES) begin
         w  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
         ch = ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
         h  = ($urandom_range(7) == 0) ? $urandom_range(32'h1FF_FFFF) : $urandom_range(5);
         set_format(w, h, ch, $urandom_range(1));
         set_idle(mode % 4);
         mode++;
         @(negedge clock);
         imgs = $urandom_range(1, 3);
         repeat (imgs) build_random_image();
         run_queued();
      end

      // Start of the widest legal row: 2048 pixels of 4 bytes
      set_format(2048, 2, 4, 0);
      set_idle(0);
      @(negedge clock);
      push_row_head(WIDE_BYTES);
      run_queued();

      // Start of a row whose width lies past the line buffer cap, 3 channels with fill
      set_format(4095, 1, 3, 1);
      set_idle(3);
      @(negedge clock);
      push_row_head(CAP_BYTES);
      run_queued();

      // Tallest heights: the image does not finish
      set_format(1, 32'h100_0000, 1, 0);
      set_idle(1);
      @(negedge clock);
      for (int r = 0; r < 5; r++) push_row(random_filter(), r == 0, 0);
      run_queued();
      set_format(3, 32'h1FF_FFFF, 7, 1);
      set_idle(2);
      @(negedge clock);
      for (int r = 0; r < 4; r++) push_row(random_filter(), r == 0, 0);
      run_queued();

      // Zero width, height and channels
      set_format(0, 0, 0, 1);
      set_idle(3);
      @(negedge clock);
      repeat (3) build_random_image();
      run_queued();

      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
